// ===== src/dmqt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmqt_pkg
// Types and constants shared by the depth map quad triangulator modules.
// ----------------------------------------------------------------------------
package dmqt_pkg;

  localparam int DEPTH_W = 16;
  localparam int COORD_W = 12;
  localparam int DIV_W   = 10;
  localparam int PROD_W  = DEPTH_W + DIV_W;
  localparam int CFG_W   = 13;

  // Configuration register indexes.
  localparam logic [1:0] REG_LINE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DIFF_DIVISOR = 2'd2;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = 13'd4096;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd4096;
  localparam logic [DIV_W-1:0] DIFF_DIVISOR_RST = 10'd20;
  localparam logic [CFG_W-1:0] MAX_HEIGHT       = 13'd4096;

  // Corners: 0 upper-left, 1 upper, 2 left, 3 current pixel.
  // The six corner pairs that form the quad's edges and diagonals.
  localparam int NUM_EDGES = 6;
  localparam logic [1:0] EDGE_A [NUM_EDGES] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] EDGE_B [NUM_EDGES] = '{2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3};
  localparam int EDGE_03 = 2;
  localparam int EDGE_12 = 3;

  // Candidate triangle for each corner that it leaves out.
  localparam logic [1:0] TRI_CORNER [4][3] = '{
    '{2'd3, 2'd1, 2'd2},
    '{2'd0, 2'd2, 2'd3},
    '{2'd3, 2'd1, 2'd0},
    '{2'd0, 2'd2, 2'd1}
  };

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [DEPTH_W-1:0] depth;
  } vertex_t;

  typedef struct packed {
    vertex_t [2:0] v;
    logic          last;
  } tri_t;

  typedef struct packed {
    logic [1:0]   n;
    tri_t [1:0]   slot;
  } tri_pair_t;

  // One quad after the edge products have been formed.
  typedef struct packed {
    logic [3:0][DEPTH_W-1:0]          d;
    logic [COORD_W-1:0]               col;
    logic [COORD_W-1:0]               row;
    logic                             en;
    logic                             diag03;
    logic [NUM_EDGES-1:0][PROD_W-1:0] prod;
    logic [NUM_EDGES-1:0][DEPTH_W-1:0] peak;
  } quad_t;

endpackage

// ===== src/depth_map_quad_triangulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_map_quad_triangulator
// Turns a raster-order depth map into triangles, one 2x2 quad per pixel.
// ----------------------------------------------------------------------------
// Pixels enter on the pix channel one item per depth sample, in raster order.
// Triangles leave on the tri channel, one item per triangle with its three
// vertices; last_tri marks the final triangle of a pixel. A pixel whose quad
// yields nothing produces no item.
// A taken pixel passes through the stage 1 registers, the stage 2 quad
// register and the output register pair before its first triangle is
// valid. A new pixel is taken every cycle while pixels give at most one
// triangle and tri_stall is low; a pixel that gives two holds the output
// pair until both of its triangles are taken.
// The previous row lives in a single-port-write, registered-read line
// memory of MAX_WIDTH entries, written and read once per pixel.
// Reset (synchronous) returns the registers to their defaults and the
// row and column counters to zero; the line memory is not cleared, and
// its contents are never used before the first row of a frame rewrites it.
// While tri_stall is high the pending triangle holds, the pipeline fills, and
// pix_stall rises once no stage is free. The user must write configuration via
// cfg_we / cfg_index / cfg_data only while the block is idle; the block does not check it.
// ----------------------------------------------------------------------------
module depth_map_quad_triangulator #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [dmqt_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          pix_valid,
  output logic                          pix_stall,
  input  logic [dmqt_pkg::DEPTH_W-1:0]  depth,
  output logic                          tri_valid,
  input  logic                          tri_stall,
  output logic [dmqt_pkg::COORD_W-1:0]  ax,
  output logic [dmqt_pkg::COORD_W-1:0]  ay,
  output logic [dmqt_pkg::DEPTH_W-1:0]  adepth,
  output logic [dmqt_pkg::COORD_W-1:0]  bx,
  output logic [dmqt_pkg::COORD_W-1:0]  by,
  output logic [dmqt_pkg::DEPTH_W-1:0]  bdepth,
  output logic [dmqt_pkg::COORD_W-1:0]  cx,
  output logic [dmqt_pkg::COORD_W-1:0]  cy,
  output logic [dmqt_pkg::DEPTH_W-1:0]  cdepth,
  output logic                          last_tri
);
  import dmqt_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int LW = (CW > CFG_W) ? CW : CFG_W;

  // Configuration registers.
  logic [CFG_W-1:0] line_width;
  logic [CFG_W-1:0] frame_height;
  logic [DIV_W-1:0] diff_divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= LINE_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      diff_divisor <= DIFF_DIVISOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LINE_WIDTH:   line_width   <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        REG_DIFF_DIVISOR: diff_divisor <= cfg_data[DIV_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake and pipeline control.
  logic      pix_fire;
  logic      tri_fire;
  logic      s1_valid;
  logic      s2_valid;
  logic      s1_move;
  logic      s2_move;
  logic [1:0] tri_n;

  assign tri_valid = (tri_n != 2'd0);
  assign tri_fire  = tri_valid && !tri_stall;
  assign s2_move   = s2_valid && ((tri_n == 2'd0) || ((tri_n == 2'd1) && tri_fire));
  assign s1_move   = s1_valid && (!s2_valid || s2_move);
  assign pix_stall = s1_valid && !s1_move;
  assign pix_fire  = pix_valid && !pix_stall;

  // Raster position of the incoming item, wrapped against the frame size.
  logic [CW-1:0]    col_count;
  logic [COORD_W-1:0] row_count;
  logic [LW-1:0]    lw_ext;
  logic [LW-1:0]    eff_width;
  logic [CFG_W-1:0] eff_height;
  logic [LW-1:0]    col_ext;
  logic             col_wrap;
  logic [LW-1:0]    col_cur;
  logic [CFG_W-1:0] row_inc;
  logic [CFG_W-1:0] row_cur;
  logic [AW-1:0]    mem_addr;

  always_comb begin
    lw_ext = LW'(line_width);
    if (lw_ext < LW'(2)) begin
      eff_width = LW'(2);
    end else if (lw_ext > LW'(MAX_WIDTH)) begin
      eff_width = LW'(MAX_WIDTH);
    end else begin
      eff_width = lw_ext;
    end
    if (frame_height < CFG_W'(2)) begin
      eff_height = CFG_W'(2);
    end else if (frame_height > MAX_HEIGHT) begin
      eff_height = MAX_HEIGHT;
    end else begin
      eff_height = frame_height;
    end
    col_ext  = LW'(col_count);
    col_wrap = (col_ext >= eff_width);
    col_cur  = col_wrap ? '0 : col_ext;
    row_inc  = CFG_W'(row_count) + CFG_W'(col_wrap);
    row_cur  = (row_inc >= eff_height) ? '0 : row_inc;
    mem_addr = col_cur[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (pix_fire) begin
      col_count <= CW'(col_cur + LW'(1));
      row_count <= row_cur[COORD_W-1:0];
    end
  end

  // Line memory: the upper neighbor is read as the current pixel replaces it.
  logic [DEPTH_W-1:0] row_mem [MAX_WIDTH];
  logic [DEPTH_W-1:0] up_pix;

  always_ff @(posedge clk) begin
    if (pix_fire) begin
      row_mem[mem_addr] <= depth;
      up_pix            <= row_mem[mem_addr];
    end
  end

  // Stage 1: the item with its position; the upper neighbor arrives from memory.
  logic [DEPTH_W-1:0] s1_cur;
  logic [COORD_W-1:0] s1_col;
  logic [COORD_W-1:0] s1_row;
  logic               s1_en;
  logic [DEPTH_W-1:0] ul_pix;
  logic [DEPTH_W-1:0] left_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_fire) begin
      s1_cur <= depth;
      s1_col <= col_cur[COORD_W-1:0];
      s1_row <= row_cur[COORD_W-1:0];
      s1_en  <= (col_cur != '0) && (row_cur != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ul_pix   <= '0;
      left_pix <= '0;
    end else if (s1_move) begin
      ul_pix   <= up_pix;
      left_pix <= s1_cur;
    end
  end

  // Edge differences scaled by the divisor.
  quad_t quad_next;
  quad_t quad;

  always_comb begin
    logic [DEPTH_W-1:0] da;
    logic [DEPTH_W-1:0] db;
    logic [DEPTH_W-1:0] diff [NUM_EDGES];

    quad_next.d[0] = ul_pix;
    quad_next.d[1] = up_pix;
    quad_next.d[2] = left_pix;
    quad_next.d[3] = s1_cur;
    quad_next.col  = s1_col;
    quad_next.row  = s1_row;
    quad_next.en   = s1_en;
    for (int e = 0; e < NUM_EDGES; e++) begin
      da = quad_next.d[EDGE_A[e]];
      db = quad_next.d[EDGE_B[e]];
      diff[e] = (da > db) ? (da - db) : (db - da);
      quad_next.peak[e] = (da > db) ? da : db;
      quad_next.prod[e] = PROD_W'(diff[e]) * PROD_W'(diff_divisor);
    end
    quad_next.diag03 = diff[EDGE_03] > diff[EDGE_12];
  end

  // Stage 2: products registered, then triangle selection.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_move) begin
      s2_valid <= 1'b1;
    end else if (s2_move) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      quad <= quad_next;
    end
  end

  tri_pair_t tri_sel;

  dmqt_tri_select u_tri_select (
    .quad   (quad),
    .result (tri_sel)
  );

  // Output pair: slot 0 is presented, slot 1 moves up after it is taken.
  tri_t slot0;
  tri_t slot1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tri_n <= 2'd0;
    end else if (s2_move) begin
      tri_n <= tri_sel.n;
    end else if (tri_fire) begin
      tri_n <= tri_n - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_move) begin
      slot0 <= tri_sel.slot[0];
      slot1 <= tri_sel.slot[1];
    end else if (tri_fire) begin
      slot0 <= slot1;
    end
  end

  assign ax       = slot0.v[0].x;
  assign ay       = slot0.v[0].y;
  assign adepth   = slot0.v[0].depth;
  assign bx       = slot0.v[1].x;
  assign by       = slot0.v[1].y;
  assign bdepth   = slot0.v[1].depth;
  assign cx       = slot0.v[2].x;
  assign cy       = slot0.v[2].y;
  assign cdepth   = slot0.v[2].depth;
  assign last_tri = slot0.last;

endmodule

// ===== src/dmqt_tri_select.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmqt_tri_select
// Picks the candidate triangles of one quad, applies the edge test and
// builds up to two triangles with their vertex coordinates.
// ----------------------------------------------------------------------------
module dmqt_tri_select (
  input  dmqt_pkg::quad_t     quad,
  output dmqt_pkg::tri_pair_t result
);
  import dmqt_pkg::*;

  always_comb begin
    logic [3:0]         zero;
    logic [2:0]         nz;
    logic [3:0]         sel;
    logic [3:0]         tri_ok;
    logic [3:0]         cand;
    logic               ok_m [4][4];
    logic [COORD_W-1:0] colm1;
    logic [COORD_W-1:0] rowm1;
    logic [1:0]         k;
    logic [1:0]         n;
    tri_t               built [4];

    for (int a = 0; a < 4; a++) begin
      for (int b = 0; b < 4; b++) begin
        ok_m[a][b] = 1'b0;
      end
    end
    for (int e = 0; e < NUM_EDGES; e++) begin
      ok_m[EDGE_A[e]][EDGE_B[e]] = quad.prod[e] < PROD_W'(quad.peak[e]);
      ok_m[EDGE_B[e]][EDGE_A[e]] = quad.prod[e] < PROD_W'(quad.peak[e]);
    end

    nz = 3'd0;
    for (int i = 0; i < 4; i++) begin
      zero[i] = (quad.d[i] == '0);
      nz = nz + 3'(!zero[i]);
    end

    // Three valid corners: the single zero corner names the triangle.
    // Four: split along the diagonal with the smaller depth step.
    if (nz == 3'd3) begin
      sel = zero;
    end else if (nz == 3'd4) begin
      sel = quad.diag03 ? 4'b1001 : 4'b0110;
    end else begin
      sel = 4'b0000;
    end

    colm1 = quad.col - COORD_W'(1);
    rowm1 = quad.row - COORD_W'(1);
    for (int t = 0; t < 4; t++) begin
      tri_ok[t] = ok_m[TRI_CORNER[t][0]][TRI_CORNER[t][1]] &
                  ok_m[TRI_CORNER[t][1]][TRI_CORNER[t][2]] &
                  ok_m[TRI_CORNER[t][2]][TRI_CORNER[t][0]];
      built[t].last = 1'b0;
      for (int j = 0; j < 3; j++) begin
        k = TRI_CORNER[t][j];
        built[t].v[j].x     = k[0] ? quad.col : colm1;
        built[t].v[j].y     = k[1] ? quad.row : rowm1;
        built[t].v[j].depth = quad.d[k];
      end
    end

    cand = sel & tri_ok & {4{quad.en}};

    result = '0;
    n = 2'd0;
    for (int t = 0; t < 4; t++) begin
      if (cand[t]) begin
        if (n == 2'd0) begin
          result.slot[0] = built[t];
        end else begin
          result.slot[1] = built[t];
        end
        n = n + 2'd1;
      end
    end
    result.n = n;
    result.slot[0].last = (n == 2'd1);
    result.slot[1].last = 1'b1;
  end

endmodule
